[rtl/rgbgtc_pkg.sv]
// shared types and constants for the rgb gradient text colorizer
// used by rgbgtc_ctrl, rgbgtc_dp and the top level; no dependencies
package rgbgtc_pkg;

    localparam int CHAR_W     = 8;
    localparam int CHAN_W     = 8;
    localparam int COLOR_W    = 24;
    localparam int STEP_W     = 12;
    localparam int PROD_W     = STEP_W + CHAN_W;
    localparam int MAG_W      = PROD_W + 2;
    localparam int QBITS      = 8;
    localparam int QCNT_W     = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int POS_BITS_DEF = 12;

    localparam logic [CHAR_W-1:0]  SPACE_CODE = 8'd32;
    localparam logic [COLOR_W-1:0] START_RST  = 24'h000000;
    localparam logic [COLOR_W-1:0] END_RST    = 24'hFFFFFF;
    localparam logic [STEP_W-1:0]  STEPS_RST  = 12'd1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START = 2'd0,
        CFG_END   = 2'd1,
        CFG_STEPS = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic div_last;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_space;
        logic last_ch;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/rgbgtc_ctrl.sv]
// colorizer sequencer: accept, per-channel multiply and divide unless space, emit
// depends on rgbgtc_pkg
module rgbgtc_ctrl
    import rgbgtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t             state_reg, state_next;
    logic [QCNT_W-1:0]  bit_cnt_reg, bit_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (status.item_space)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.mul      = 1'b1;
                    bit_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div      = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == QCNT_W'(QBITS - 1))
                begin
                    cmd.div_last = 1'b1;
                    state_next   = status.last_ch ? ST_DONE : ST_MUL;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/rgbgtc_dp.sv]
// datapath: gradient position, channel multiply, shared restoring divider,
// output register; depends on rgbgtc_pkg, driven by rgbgtc_ctrl
module rgbgtc_dp
    import rgbgtc_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic [CHAR_W-1:0]  char_in,
    input  logic               first_in,
    input  logic [COLOR_W-1:0] cfg_start,
    input  logic [COLOR_W-1:0] cfg_end,
    input  logic [STEP_W-1:0]  cfg_steps,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [CHAR_W-1:0]  out_char,
    output logic               out_colored,
    output logic [CHAN_W-1:0]  out_red,
    output logic [CHAN_W-1:0]  out_green,
    output logic [CHAN_W-1:0]  out_blue
);

    localparam int CMP_W = (POS_BITS > STEP_W) ? POS_BITS : STEP_W;
    localparam logic [CMP_W-1:0] POS_MAX = CMP_W'((32'd1 << POS_BITS) - 32'd1);

    logic [POS_BITS-1:0] pos_reg;
    logic [STEP_W-1:0]   p_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic                space_reg;
    logic [1:0]          ch_reg;
    logic [MAG_W-1:0]    rem_reg;
    logic [MAG_W-1:0]    div_reg;
    logic [QBITS-1:0]    q_reg;
    logic                neg_reg;
    logic [CHAN_W-1:0]   a_reg;
    logic [CHAN_W-1:0]   red_reg, green_reg, blue_reg;
    logic                out_valid_reg;

    // position update at accept
    logic [POS_BITS-1:0] pos_eff;
    logic [CMP_W-1:0]    pos_x, steps_x, p_x, limit_x, adv_x;
    logic                in_space;

    always_comb
    begin
        in_space = (char_in == SPACE_CODE);
        pos_eff  = first_in ? '0 : pos_reg;
        pos_x    = CMP_W'(pos_eff);
        steps_x  = CMP_W'(cfg_steps);
        p_x      = (pos_x > steps_x) ? steps_x : pos_x;
        limit_x  = (steps_x > POS_MAX) ? POS_MAX : steps_x;
        adv_x    = (p_x < limit_x) ? p_x + 1'b1 : p_x;
    end

    // channel selection and product
    logic [CHAN_W-1:0] a_sel, b_sel, diff;
    logic              neg;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  mag;

    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                a_sel = cfg_start[23:16];
                b_sel = cfg_end[23:16];
            end
            2'd1:
            begin
                a_sel = cfg_start[15:8];
                b_sel = cfg_end[15:8];
            end
            default:
            begin
                a_sel = cfg_start[7:0];
                b_sel = cfg_end[7:0];
            end
        endcase
        neg  = (b_sel < a_sel);
        diff = neg ? (a_sel - b_sel) : (b_sel - a_sel);
        prod = PROD_W'(p_reg) * PROD_W'(diff);
        mag  = (MAG_W'(prod) << 1) + MAG_W'(cfg_steps);
    end

    // one restoring divide step
    logic              ge;
    logic [QBITS-1:0]  q_next;
    logic [QBITS-1:0]  q_fin;
    logic [CHAN_W-1:0] chan_val;

    always_comb
    begin
        ge       = (rem_reg >= div_reg);
        q_next   = {q_reg[QBITS-2:0], ge};
        // zero steps means start colour
        q_fin    = (cfg_steps == '0) ? '0 : q_next;
        chan_val = neg_reg ? (a_reg - CHAN_W'(q_fin)) : (a_reg + CHAN_W'(q_fin));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.load)
        begin
            pos_reg <= in_space ? pos_eff : adv_x[POS_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg  <= char_in;
            space_reg <= in_space;
            p_reg     <= p_x[STEP_W-1:0];
            ch_reg    <= 2'd0;
        end
        if (cmd.mul)
        begin
            rem_reg <= mag;
            div_reg <= MAG_W'({cfg_steps, 1'b0}) << (QBITS - 1);
            q_reg   <= '0;
            neg_reg <= neg;
            a_reg   <= a_sel;
        end
        if (cmd.div)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            div_reg <= div_reg >> 1;
            q_reg   <= q_next;
        end
        if (cmd.div_last)
        begin
            case (ch_reg)
                2'd0:    red_reg   <= chan_val;
                2'd1:    green_reg <= chan_val;
                default: blue_reg  <= chan_val;
            endcase
            ch_reg <= ch_reg + 2'd1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char    <= char_reg;
            out_colored <= ~space_reg;
            out_red     <= space_reg ? '0 : red_reg;
            out_green   <= space_reg ? '0 : green_reg;
            out_blue    <= space_reg ? '0 : blue_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status.item_space = space_reg;
    assign status.last_ch    = (ch_reg == 2'd2);
    assign status.out_free   = ~out_valid_reg | out_ready;

endmodule

[rtl/rgb_gradient_text_colorizer_unit.sv]
// non-space character: one multiply and eight divide steps per channel on one
// shared restoring divider; a space skips the multiply and divide steps; a new
// character is taken only once the last result is registered, even if that
// result is not yet taken downstream
// rst_n (async, active low) clears position to zero and loads the reset colours
// and step count; depends on rgbgtc_pkg, rgbgtc_ctrl, rgbgtc_dp
module rgb_gradient_text_colorizer_unit
    import rgbgtc_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // char_code
    input  logic [0:0]            s_axis_tuser,   // first_char
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // out_char, red, green, blue
    output logic [0:0]            m_axis_tuser,   // colored
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COLOR_W-1:0]    cfg_wdata
);

    logic [COLOR_W-1:0] start_reg;
    logic [COLOR_W-1:0] end_reg;
    logic [STEP_W-1:0]  steps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RST;
            end_reg   <= END_RST;
            steps_reg <= STEPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_START: start_reg <= cfg_wdata;
                CFG_END:   end_reg   <= cfg_wdata;
                CFG_STEPS: steps_reg <= cfg_wdata[STEP_W-1:0];
                default:   ;
            endcase
        end
    end

    ctrl_cmd_t  cmd;
    dp_status_t status;

    logic [CHAR_W-1:0] out_char;
    logic              out_colored;
    logic [CHAN_W-1:0] out_red, out_green, out_blue;

    rgbgtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rgbgtc_dp #(
        .POS_BITS (POS_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .char_in     (s_axis_tdata),
        .first_in    (s_axis_tuser[0]),
        .cfg_start   (start_reg),
        .cfg_end     (end_reg),
        .cfg_steps   (steps_reg),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_char    (out_char),
        .out_colored (out_colored),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue)
    );

    assign m_axis_tdata = {out_blue, out_green, out_red, out_char};
    assign m_axis_tuser = out_colored;

endmodule
